FILE: hdl/assert_macros.svh
// Assertion macros for the converter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define RPC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/rpc_pkg.sv
// Shared constants, control struct and arctangent table for the converter.
package rpc_pkg;

   localparam int ZW          = 32;   // angle accumulator, 2^32 per turn
   localparam int GUARD       = 16;   // fraction bits of the datapath
   localparam int ROUND_SHIFT = GUARD + 5;

   localparam logic [29:0]   GAIN_Q30  = 30'd652032874;
   localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

   localparam logic [1:0] FUNC_RECT  = 2'd0;
   localparam logic [1:0] FUNC_POLAR = 2'd1;

   typedef struct packed {
      logic rot;   // rotation (polar to rect)
      logic err;   // invalid mode
      logic org;   // vectoring input at the origin
   } rpc_ctl_type;

   // round(atan(2^-i) * 2^32 / (2*pi))
   function automatic logic [ZW-1:0] atan_val(input int unsigned idx);
      logic [ZW-1:0] v;
      case (idx & 32'd31)
         0:  v = 32'd536870912;
         1:  v = 32'd316933406;
         2:  v = 32'd167458907;
         3:  v = 32'd85004756;
         4:  v = 32'd42667331;
         5:  v = 32'd21354465;
         6:  v = 32'd10679838;
         7:  v = 32'd5340245;
         8:  v = 32'd2670163;
         9:  v = 32'd1335087;
         10: v = 32'd667544;
         11: v = 32'd333772;
         12: v = 32'd166886;
         13: v = 32'd83443;
         14: v = 32'd41722;
         15: v = 32'd20861;
         16: v = 32'd10430;
         17: v = 32'd5215;
         18: v = 32'd2608;
         19: v = 32'd1304;
         20: v = 32'd652;
         21: v = 32'd326;
         22: v = 32'd163;
         23: v = 32'd81;
         24: v = 32'd41;
         25: v = 32'd20;
         26: v = 32'd10;
         27: v = 32'd5;
         28: v = 32'd3;
         29: v = 32'd1;
         30: v = 32'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: hdl/rpc_pre.sv
// Input stage: mode decode, half-plane and quadrant pre-rotation.
module rpc_pre #(
   parameter int DATA_WIDTH = 16,
   parameter int XW         = 35
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [1:0]                   in_func,
   input  logic signed [DATA_WIDTH-1:0] in_first,
   input  logic signed [DATA_WIDTH-1:0] in_second,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [XW-1:0]         out_x,
   output logic signed [XW-1:0]         out_y,
   output logic [rpc_pkg::ZW-1:0]       out_z,
   output rpc_pkg::rpc_ctl_type         out_ctl
);
   import rpc_pkg::*;

   logic                 vld_ff;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] y_ff, y_in;
   logic [ZW-1:0]        z_ff, z_in;
   rpc_ctl_type          ctl_ff, ctl_in;

   logic signed [XW-1:0] fx, sy;
   logic [ZW-1:0]        sec_u, ang_z;

   always_comb begin
      fx     = XW'(in_first) <<< GUARD;
      sy     = XW'(in_second) <<< GUARD;
      sec_u  = ZW'(unsigned'(in_second));
      ang_z  = {sec_u[15:0], 16'h0000};
      x_in   = fx;
      y_in   = sy;
      z_in   = '0;
      ctl_in = '0;
      case (in_func)
         FUNC_RECT: begin
            ctl_in.org = (in_first == '0) && (in_second == '0);
            if (in_first < 0) begin
               x_in = -fx;
               y_in = -sy;
               z_in = HALF_TURN;
            end
         end
         FUNC_POLAR: begin
            ctl_in.rot = 1'b1;
            y_in       = '0;
            // second or third quarter: flip the vector, move by half a turn
            if (ang_z[ZW-1] ^ ang_z[ZW-2]) begin
               x_in = -fx;
               z_in = ang_z ^ HALF_TURN;
            end else begin
               z_in = ang_z;
            end
         end
         default: begin
            ctl_in.err = 1'b1;
         end
      endcase
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         ctl_ff <= ctl_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_ctl   = ctl_ff;

endmodule

FILE: hdl/rpc_stage.sv
// One registered CORDIC micro-rotation.
module rpc_stage #(
   parameter int XW    = 35,
   parameter int SHIFT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [XW-1:0]   in_x,
   input  logic signed [XW-1:0]   in_y,
   input  logic [rpc_pkg::ZW-1:0] in_z,
   input  rpc_pkg::rpc_ctl_type   in_ctl,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic signed [XW-1:0]   out_x,
   output logic signed [XW-1:0]   out_y,
   output logic [rpc_pkg::ZW-1:0] out_z,
   output rpc_pkg::rpc_ctl_type   out_ctl
);
   import rpc_pkg::*;

   localparam logic [ZW-1:0] ATAN = atan_val(SHIFT);

   logic                 vld_ff;
   logic signed [XW-1:0] x_ff, x_in;
   logic signed [XW-1:0] y_ff, y_in;
   logic [ZW-1:0]        z_ff, z_in;
   rpc_ctl_type          ctl_ff;

   logic signed [XW-1:0] xs, ys;
   logic                 dir;

   always_comb begin
      xs  = in_x >>> SHIFT;
      ys  = in_y >>> SHIFT;
      // rotation drives z to zero, vectoring drives y to zero
      dir = in_ctl.rot ? !in_z[ZW-1] : in_y[XW-1];
      if (dir) begin
         x_in = in_x - ys;
         y_in = in_y + xs;
         z_in = in_z - ATAN;
      end else begin
         x_in = in_x + ys;
         y_in = in_y - xs;
         z_in = in_z + ATAN;
      end
   end

   assign in_ready = !vld_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         ctl_ff <= in_ctl;
      end
   end

   assign out_valid = vld_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_ctl   = ctl_ff;

endmodule

FILE: hdl/rpc_gain.sv
// Gain compensation, rounding, saturation and result select (four stages).
module rpc_gain #(
   parameter int DATA_WIDTH = 16,
   parameter int XW         = 35
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [XW-1:0]         in_x,
   input  logic signed [XW-1:0]         in_y,
   input  logic [rpc_pkg::ZW-1:0]       in_z,
   input  rpc_pkg::rpc_ctl_type         in_ctl,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [DATA_WIDTH:0]   out_first,
   output logic signed [DATA_WIDTH-1:0] out_second,
   output logic                         out_error
);
   import rpc_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int PW = XW + 5;      // high partial product
   localparam int LW = 55;          // 25 x 30 low partial product
   localparam int TW = XW + 6;      // sum
   localparam int RW = DW + 5;      // signed rounded value
   localparam logic [TW-1:0] RND = TW'(1) << (ROUND_SHIFT - 1);

   localparam logic signed [RW-1:0] X_HI = {{5{1'b0}}, {DW{1'b1}}};
   localparam logic signed [RW-1:0] X_LO = {{5{1'b1}}, {DW{1'b0}}};
   localparam logic signed [RW-1:0] Y_HI = {{6{1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [RW-1:0] Y_LO = {{6{1'b1}}, {(DW-1){1'b0}}};

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   // s1: magnitudes, output angle
   logic [XW-1:0] ax1_ff, ay1_ff, ax1_in, ay1_in;
   logic          nx1_ff, ny1_ff;
   logic [15:0]   ang1_ff;
   logic [ZW-1:0] zr;
   rpc_ctl_type   ctl1_ff;

   // s2: partial products
   logic [PW-1:0] phx2_ff, phy2_ff;
   logic [LW-1:0] plx2_ff, ply2_ff;
   logic          nx2_ff, ny2_ff;
   logic [15:0]   ang2_ff;
   rpc_ctl_type   ctl2_ff;

   // s3: rounded magnitudes
   logic [TW-1:0] tx, ty, rtx, rty;
   logic [DW+3:0] rx3_ff, ry3_ff;
   logic          nx3_ff, ny3_ff;
   logic [15:0]   ang3_ff;
   rpc_ctl_type   ctl3_ff;

   // s4: output register
   logic signed [RW-1:0] sx, sy;
   logic signed [RW-1:0] cx, cy;
   logic [ZW-1:0]        ang_ext;
   logic signed [DW:0]   rf_ff, rf_in;
   logic signed [DW-1:0] rs_ff, rs_in;
   logic                 err_ff;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_comb begin
      ax1_in = in_x[XW-1] ? unsigned'(-in_x) : unsigned'(in_x);
      ay1_in = in_y[XW-1] ? unsigned'(-in_y) : unsigned'(in_y);
      zr     = in_z + ZW'(32'h8000);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         ax1_ff  <= ax1_in;
         ay1_ff  <= ay1_in;
         nx1_ff  <= in_x[XW-1];
         ny1_ff  <= in_y[XW-1];
         ang1_ff <= zr[ZW-1:ZW-16];
         ctl1_ff <= in_ctl;
      end
   end

   // |v| * K split at bit 25 so each product stays within one multiplier
   always_ff @(posedge clock) begin
      if (rdy2) begin
         phx2_ff <= PW'(ax1_ff[XW-1:25]) * PW'(GAIN_Q30);
         phy2_ff <= PW'(ay1_ff[XW-1:25]) * PW'(GAIN_Q30);
         plx2_ff <= LW'(ax1_ff[24:0]) * LW'(GAIN_Q30);
         ply2_ff <= LW'(ay1_ff[24:0]) * LW'(GAIN_Q30);
         nx2_ff  <= nx1_ff;
         ny2_ff  <= ny1_ff;
         ang2_ff <= ang1_ff;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_comb begin
      tx  = TW'(phx2_ff) + TW'(plx2_ff[LW-1:25]);
      ty  = TW'(phy2_ff) + TW'(ply2_ff[LW-1:25]);
      rtx = tx + RND;
      rty = ty + RND;
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         rx3_ff  <= rtx[TW-1:ROUND_SHIFT];
         ry3_ff  <= rty[TW-1:ROUND_SHIFT];
         nx3_ff  <= nx2_ff;
         ny3_ff  <= ny2_ff;
         ang3_ff <= ang2_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_comb begin
      sx      = nx3_ff ? -signed'({1'b0, rx3_ff}) : signed'({1'b0, rx3_ff});
      sy      = ny3_ff ? -signed'({1'b0, ry3_ff}) : signed'({1'b0, ry3_ff});
      cx      = (sx > X_HI) ? X_HI : ((sx < X_LO) ? X_LO : sx);
      cy      = (sy > Y_HI) ? Y_HI : ((sy < Y_LO) ? Y_LO : sy);
      ang_ext = {{16{ang3_ff[15]}}, ang3_ff};
      rf_in   = cx[DW:0];
      if (ctl3_ff.err) begin
         rf_in = '0;
         rs_in = '0;
      end else if (ctl3_ff.rot) begin
         rs_in = cy[DW-1:0];
      end else if (ctl3_ff.org) begin
         rs_in = '0;
      end else begin
         rs_in = signed'(ang_ext[DW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         rf_ff  <= rf_in;
         rs_ff  <= rs_in;
         err_ff <= ctl3_ff.err;
      end
   end

   assign out_valid  = v4_ff;
   assign out_first  = rf_ff;
   assign out_second = rs_ff;
   assign out_error  = err_ff;

endmodule

FILE: hdl/rect_polar_converter_core.sv
// Top level of the pipelined CORDIC rectangular/polar converter.
//
//   channel | dir | tdata (low bit up)                    | tuser
//   --------+-----+---------------------------------------+------------
//   req     | in  | first_value, second_value, zero pad   | func
//   rsp     | out | result_first, result_second, zero pad | mode_error
//
// One request per clock, sustained while responses are accepted. The pipeline is
// one input stage, one register per CORDIC micro-rotation and four gain stages
// (magnitude, partial products, round, saturate/select into the output register).
// Reset clears only the valid bits; no clearing pass, no stored state.
// Each stage is ready when empty or when the stage after it moves, so bubbles
// close up under backpressure and a stalled response holds in place.
`include "assert_macros.svh"

module rect_polar_converter_core #(
   parameter int DATA_WIDTH = 16,
   parameter int ITERATIONS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // req: func in tuser; tdata = first_value, second_value
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]         req_tdata,
   input  logic [1:0]                                req_tuser,
   // rsp: mode_error in tuser; tdata = result_first, result_second
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [((2*DATA_WIDTH+1+7)/8)*8-1:0]       rsp_tdata,
   output logic                                      rsp_tuser
);
   import rpc_pkg::*;

   // Datapath width: input scaled by 2^GUARD plus CORDIC growth and sign.
   localparam int XW    = DATA_WIDTH + GUARD + 3;
   localparam int RSP_W = ((2*DATA_WIDTH+1+7)/8)*8;
   localparam int PAD_W = RSP_W - (2*DATA_WIDTH + 1);

   logic signed [DATA_WIDTH-1:0] first_value, second_value;
   logic signed [DATA_WIDTH:0]   result_first;
   logic signed [DATA_WIDTH-1:0] result_second;
   logic                         mode_error;

   // Stage 0 is the input stage; stage k+1 follows micro-rotation k.
   logic [ITERATIONS:0]  st_valid;
   logic [ITERATIONS:0]  st_ready;
   logic signed [XW-1:0] st_x   [0:ITERATIONS];
   logic signed [XW-1:0] st_y   [0:ITERATIONS];
   logic [ZW-1:0]        st_z   [0:ITERATIONS];
   rpc_ctl_type          st_ctl [0:ITERATIONS];

   assign first_value  = signed'(req_tdata[DATA_WIDTH-1:0]);
   assign second_value = signed'(req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);

   rpc_pre #(
      .DATA_WIDTH(DATA_WIDTH),
      .XW        (XW)
   ) u_pre (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_func  (req_tuser),
      .in_first (first_value),
      .in_second(second_value),
      .out_valid(st_valid[0]),
      .out_ready(st_ready[0]),
      .out_x    (st_x[0]),
      .out_y    (st_y[0]),
      .out_z    (st_z[0]),
      .out_ctl  (st_ctl[0])
   );

   for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
      rpc_stage #(
         .XW   (XW),
         .SHIFT(g)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .in_valid (st_valid[g]),
         .in_ready (st_ready[g]),
         .in_x     (st_x[g]),
         .in_y     (st_y[g]),
         .in_z     (st_z[g]),
         .in_ctl   (st_ctl[g]),
         .out_valid(st_valid[g+1]),
         .out_ready(st_ready[g+1]),
         .out_x    (st_x[g+1]),
         .out_y    (st_y[g+1]),
         .out_z    (st_z[g+1]),
         .out_ctl  (st_ctl[g+1])
      );
   end

   rpc_gain #(
      .DATA_WIDTH(DATA_WIDTH),
      .XW        (XW)
   ) u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (st_valid[ITERATIONS]),
      .in_ready  (st_ready[ITERATIONS]),
      .in_x      (st_x[ITERATIONS]),
      .in_y      (st_y[ITERATIONS]),
      .in_z      (st_z[ITERATIONS]),
      .in_ctl    (st_ctl[ITERATIONS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_first (result_first),
      .out_second(result_second),
      .out_error (mode_error)
   );

   assign rsp_tdata = {{PAD_W{1'b0}}, result_second, result_first};
   assign rsp_tuser = mode_error;

   // Invalid mode always comes out with both results zero.
   `RPC_ASSERT_IMP(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "mode error with nonzero result")

   // Backpressure only originates at the response side.
   `RPC_ASSERT_IMP(a_stall_src, clock, reset, !req_tready, rsp_tvalid && !rsp_tready, "request stalled without a held response")

   // The pipeline is empty after a reset cycle.
   `RPC_ASSERT_NXT(a_rst_empty, clock, 1'b0, reset, !rsp_tvalid, "response valid right after reset")

endmodule
